>>> sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared constants and types for the round-robin task ring scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int MAX_TASKS       = 16;
	localparam int SLOT_W          = $clog2(MAX_TASKS);
	localparam int REAP_SCAN_LIMIT = 64;
	localparam int REAP_CNT_W      = $clog2(REAP_SCAN_LIMIT + 1);
	localparam int LIVE_W          = 9;
	localparam int MS_PER_S        = 1000;
	localparam int MS_REM_W        = $clog2(MS_PER_S);
	localparam int CMD_W           = 3;
	localparam int STATUS_W        = 2;
	localparam int TICK_RATE_W     = 20;
	localparam int WORD_W          = 32;
	localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = TICK_RATE_W'(1000);

	// x / 1000 == (x * DIV1000_RECIP) >> DIV1000_SHIFT for every 32-bit x
	localparam logic [WORD_W-1:0] DIV1000_RECIP = 32'h1062_4DD3;
	localparam int                DIV1000_SHIFT = 38;

	localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SLEEP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_KILL     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd4;

	localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] RES_FAIL    = 2'd1;
	localparam logic [STATUS_W-1:0] RES_CURRENT = 2'd2;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_SLEEP = 2'd1,
		ST_DEAD  = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [WORD_W-1:0]   quot;
		logic [MS_REM_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> sv/rrts_ifs.sv
// ----------------------------------------------------------------------------
// rrts channel interfaces
// Command, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrts_cmd_if import rrts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [WORD_W-1:0] now_tick;
	logic [WORD_W-1:0] delay_ms;
	logic [WORD_W-1:0] target_id;

	modport source (output valid, command, now_tick, delay_ms, target_id, input ready);
	modport sink   (input valid, command, now_tick, delay_ms, target_id, output ready);
endinterface

interface rrts_res_if import rrts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   running_id;
	logic                switched;
	logic [WORD_W-1:0]   created_id;
	logic [LIVE_W-1:0]   live_count;

	modport source (output valid, status, running_id, switched, created_id, live_count,
		input ready);
	modport sink   (input valid, status, running_id, switched, created_id, live_count,
		output ready);
endinterface

interface rrts_cfg_if import rrts_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [TICK_RATE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> sv/rrts_div1000.sv
// ----------------------------------------------------------------------------
// rrts_div1000
// Reciprocal-multiply divide by MS_PER_S: product registered, then the result.
// ----------------------------------------------------------------------------
module rrts_div1000 import rrts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  step_q;
	logic                  done_q;
	logic [2*WORD_W-1:0]   prod_q;
	logic [WORD_W-1:0]     dvd_q;
	logic [WORD_W-1:0]     quot_q;
	logic [MS_REM_W-1:0]   rem_q;
	logic [WORD_W-1:0]     quot_c;
	logic [WORD_W-1:0]     back_c;

	assign quot_c = WORD_W'(prod_q >> DIV1000_SHIFT);
	assign back_c = quot_c * WORD_W'(MS_PER_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= req.start;
			done_q <= step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			prod_q <= req.dividend * DIV1000_RECIP;
		end
		if (step_q) begin
			quot_q <= quot_c;
			rem_q  <= MS_REM_W'(dvd_q - back_c);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

>>> sv/round_robin_task_ring_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_task_ring_scheduler_core
// Task slot table, ring walker sequencer and result register.
// ----------------------------------------------------------------------------
// One command at a time: cmd.ready is low from the transfer until the sequencer
// is back in idle. The sequencer walks the ring one slot per cycle, save for the
// hold in the last count step noted below, and each walk visits at most
// MAX_TASKS slots. Schedule and exit take a reap walk, a pick setup step, a
// pick walk, a count setup step and a count walk. Create, kill and an unknown
// command end in the count setup step and a count walk, after a create step,
// the kill walk or nothing before them. Sleep runs the ms-to-tick conversion
// ahead of the schedule, two passes of a reciprocal divide by 1000 around the
// multiply steps S_MUL_A and S_MUL_B. A finished result waits in the output
// register while the next command runs; that command then holds in its last
// count step until the first result is taken. Tick rate writes are taken only
// in idle and win over a command offered in the same cycle.
module round_robin_task_ring_scheduler_core import rrts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rrts_cmd_if.sink   cmd,
	rrts_res_if.source res,
	rrts_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_CREATE, S_DQ_GO, S_DQ_WAIT, S_MUL_A, S_MUL_B, S_DR_GO, S_DR_WAIT,
		S_REAP, S_PICK_INIT, S_PICK, S_KILL, S_CNT_INIT, S_COUNT
	} state_t;

	state_t state_q;

	logic                   slot_in_use_q  [MAX_TASKS];
	slot_state_t            slot_status_q  [MAX_TASKS];
	logic [WORD_W-1:0]      slot_task_id_q [MAX_TASKS];
	logic [WORD_W-1:0]      slot_wake_q    [MAX_TASKS];
	logic [SLOT_W-1:0]      slot_succ_q    [MAX_TASKS];
	logic [SLOT_W-1:0]      cur_q;
	logic [WORD_W-1:0]      id_counter_q;
	logic [TICK_RATE_W-1:0] tick_rate_q;

	logic [WORD_W-1:0]      now_q;
	logic [WORD_W-1:0]      delay_q;
	logic [WORD_W-1:0]      target_q;

	logic [SLOT_W-1:0]      walk_q;
	logic [REAP_CNT_W-1:0]  reap_cnt_q;
	logic [LIVE_W-1:0]      live_q;
	logic [WORD_W-1:0]      prod_a_q;
	logic [MS_REM_W-1:0]    rem_q;
	logic [MS_REM_W+TICK_RATE_W-1:0] prod_b_q;

	logic [STATUS_W-1:0]    work_status_q;
	logic                   work_switched_q;
	logic [WORD_W-1:0]      work_created_q;

	logic                   res_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   switched_q;
	logic [WORD_W-1:0]      created_q;
	logic [WORD_W-1:0]      running_q;
	logic [LIVE_W-1:0]      live_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                   free_found;
	logic [SLOT_W-1:0]      free_slot;
	logic [SLOT_W-1:0]      nxt;
	slot_state_t            nxt_st;
	slot_state_t            walk_st;
	logic                   woke;
	logic                   res_load;
	logic [WORD_W+TICK_RATE_W-1:0] mul_a;

	rrts_div1000 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!slot_in_use_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	assign nxt     = slot_succ_q[walk_q];
	assign nxt_st  = slot_status_q[nxt];
	assign walk_st = slot_status_q[walk_q];
	assign woke    = (walk_st == ST_SLEEP) && (now_q >= slot_wake_q[walk_q]);
	assign mul_a   = prod_a_q * tick_rate_q;

	// last count step, output register free or being emptied this cycle
	assign res_load = (state_q == S_COUNT) && (nxt == cur_q) && (!res_valid_q || res.ready);

	assign div_req.start    = (state_q == S_DQ_GO) || (state_q == S_DR_GO);
	assign div_req.dividend = (state_q == S_DQ_GO) ? delay_q : WORD_W'(prod_b_q);

	assign cmd.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE);

	assign res.valid      = res_valid_q;
	assign res.status     = status_q;
	assign res.running_id = running_q;
	assign res.switched   = switched_q;
	assign res.created_id = created_q;
	assign res.live_count = live_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			id_counter_q <= WORD_W'(1);
			tick_rate_q  <= TICK_RATE_RST;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				slot_in_use_q[i]  <= (i == 0);
				slot_status_q[i]  <= ST_READY;
				slot_task_id_q[i] <= '0;
				slot_wake_q[i]    <= '0;
				slot_succ_q[i]    <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				tick_rate_q <= cfg.data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						now_q           <= cmd.now_tick;
						delay_q         <= cmd.delay_ms;
						target_q        <= cmd.target_id;
						work_status_q   <= RES_OK;
						work_switched_q <= 1'b0;
						work_created_q  <= '0;
						walk_q          <= cur_q;
						reap_cnt_q      <= '0;
						case (cmd.command)
							CMD_SCHEDULE: state_q <= S_REAP;
							CMD_CREATE:   state_q <= S_CREATE;
							CMD_SLEEP:    state_q <= S_DQ_GO;
							CMD_KILL: begin
								work_status_q <= RES_FAIL;
								state_q       <= S_KILL;
							end
							CMD_EXIT: begin
								slot_status_q[cur_q] <= ST_DEAD;
								state_q              <= S_REAP;
							end
							default:      state_q <= S_CNT_INIT;
						endcase
					end
				end
				S_CREATE: begin
					if (!free_found) begin
						work_status_q <= RES_FAIL;
					end else begin
						slot_in_use_q[free_slot]  <= 1'b1;
						slot_status_q[free_slot]  <= ST_READY;
						slot_task_id_q[free_slot] <= id_counter_q;
						slot_wake_q[free_slot]    <= '0;
						slot_succ_q[free_slot]    <= slot_succ_q[cur_q];
						slot_succ_q[cur_q]        <= free_slot;
						work_created_q            <= id_counter_q;
						id_counter_q              <= id_counter_q + 1'b1;
					end
					state_q <= S_CNT_INIT;
				end
				S_DQ_GO: state_q <= S_DQ_WAIT;
				S_DQ_WAIT: begin
					if (div_rsp.done) begin
						prod_a_q <= div_rsp.quot;
						rem_q    <= div_rsp.rem;
						state_q  <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					// whole seconds times rate, wraps mod 2^32
					prod_a_q <= mul_a[WORD_W-1:0];
					state_q  <= S_MUL_B;
				end
				S_MUL_B: begin
					prod_b_q <= rem_q * tick_rate_q;
					state_q  <= S_DR_GO;
				end
				S_DR_GO: state_q <= S_DR_WAIT;
				S_DR_WAIT: begin
					if (div_rsp.done) begin
						slot_wake_q[cur_q]   <= now_q + prod_a_q + div_rsp.quot;
						slot_status_q[cur_q] <= ST_SLEEP;
						state_q              <= S_REAP;
					end
				end
				S_REAP: begin
					// walk_q is the predecessor of the slot under test
					if (reap_cnt_q == REAP_CNT_W'(REAP_SCAN_LIMIT) || nxt == cur_q) begin
						state_q <= S_PICK_INIT;
					end else if (nxt_st == ST_DEAD) begin
						slot_succ_q[walk_q] <= slot_succ_q[nxt];
						slot_in_use_q[nxt]  <= 1'b0;
						state_q             <= S_PICK_INIT;
					end else begin
						walk_q     <= nxt;
						reap_cnt_q <= reap_cnt_q + 1'b1;
					end
				end
				S_PICK_INIT: begin
					walk_q  <= slot_succ_q[cur_q];
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (woke) begin
						slot_status_q[walk_q] <= ST_READY;
					end
					if (woke || walk_st == ST_READY) begin
						if (walk_q != cur_q) begin
							cur_q           <= walk_q;
							work_switched_q <= 1'b1;
						end
						state_q <= S_CNT_INIT;
					end else if (walk_q == cur_q) begin
						state_q <= S_CNT_INIT;
					end else begin
						walk_q <= nxt;
					end
				end
				S_KILL: begin
					if (slot_task_id_q[walk_q] == target_q && walk_st != ST_DEAD) begin
						if (walk_q == cur_q) begin
							work_status_q <= RES_CURRENT;
						end else begin
							slot_status_q[walk_q] <= ST_DEAD;
							work_status_q         <= RES_OK;
						end
						state_q <= S_CNT_INIT;
					end else if (nxt == cur_q) begin
						state_q <= S_CNT_INIT;
					end else begin
						walk_q <= nxt;
					end
				end
				S_CNT_INIT: begin
					walk_q  <= cur_q;
					live_q  <= '0;
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					if (res_load) begin
						status_q   <= work_status_q;
						switched_q <= work_switched_q;
						created_q  <= work_created_q;
						live_out_q <= live_q + LIVE_W'(walk_st != ST_DEAD);
						running_q  <= slot_task_id_q[cur_q];
						state_q    <= S_IDLE;
					end else if (nxt != cur_q) begin
						live_q <= live_q + LIVE_W'(walk_st != ST_DEAD);
						walk_q <= nxt;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.running_id)
			&& $stable(res.live_count)))
		else $error("pending result dropped or changed");

	a_current_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		slot_in_use_q[cur_q])
		else $error("current slot is not in use");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DQ_WAIT || state_q == S_DR_WAIT))
		else $error("divider finished outside a wait state");

	a_result_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q) == S_COUNT)
		else $error("result raised outside the count walk");
`endif

endmodule

>>> dv/round_robin_task_ring_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_task_ring_scheduler_core_tb
// Drives scheduler commands with random gaps, and tick rate writes once all
// results have drained. A local copy of the slot ring predicts each result
// but for typed table rows; results are compared field by field, in order.
// ----------------------------------------------------------------------------
module round_robin_task_ring_scheduler_core_tb;
	import rrts_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM   = 1625;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   running_id;
		logic                switched;
		logic [WORD_W-1:0]   created_id;
		logic [LIVE_W-1:0]   live_count;
	} sched_res_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [WORD_W-1:0] now_tick;
		logic [WORD_W-1:0] delay_ms;
		logic [WORD_W-1:0] target_id;
		logic              typed;
		sched_res_t        res;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrts_cmd_if cmd_ch ();
	rrts_res_if res_ch ();
	rrts_cfg_if cfg_ch ();

	round_robin_task_ring_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// ring copy
	logic                   ring_used [MAX_TASKS];
	slot_state_t            ring_state[MAX_TASKS];
	logic [WORD_W-1:0]      ring_id   [MAX_TASKS];
	logic [WORD_W-1:0]      ring_wake [MAX_TASKS];
	logic [SLOT_W-1:0]      ring_next [MAX_TASKS];
	logic [SLOT_W-1:0]      cur_slot;
	logic [WORD_W-1:0]      next_task_id;
	logic [WORD_W-1:0]      rate_hz;

	sched_res_t pending_res[$];
	int  errors = 0;
	int  idle_cycles = 0;
	logic [WORD_W-1:0] tick_now = '0;

	task automatic ring_reset();
		for (int i = 0; i < MAX_TASKS; i++) begin
			ring_used[i]  = (i == 0);
			ring_state[i] = ST_READY;
			ring_id[i]    = '0;
			ring_wake[i]  = '0;
			ring_next[i]  = '0;
		end
		cur_slot     = '0;
		next_task_id = 32'd1;
		rate_hz      = 32'(TICK_RATE_RST);
	endtask

	function automatic void free_dead_slot();
		logic [SLOT_W-1:0] p, n;
		p = cur_slot;
		for (int i = 0; i < REAP_SCAN_LIMIT; i++) begin
			n = ring_next[p];
			if (n == cur_slot) return;
			if (ring_state[n] == ST_DEAD) begin
				ring_next[p] = ring_next[n];
				ring_used[n] = 1'b0;
				return;
			end
			p = n;
		end
	endfunction

	function automatic logic ring_sched(logic [WORD_W-1:0] now);
		logic [SLOT_W-1:0] t;
		free_dead_slot();
		t = ring_next[cur_slot];
		for (int i = 0; i < 256; i++) begin
			if (ring_state[t] == ST_SLEEP && now >= ring_wake[t])
				ring_state[t] = ST_READY;
			if (ring_state[t] == ST_READY) begin
				if (t != cur_slot) begin
					cur_slot = t;
					return 1'b1;
				end
				return 1'b0;
			end
			if (t == cur_slot) break;
			t = ring_next[t];
		end
		return 1'b0;
	endfunction

	function automatic sched_res_t predict_cmd(logic [CMD_W-1:0] c, logic [WORD_W-1:0] now,
		logic [WORD_W-1:0] ms, logic [WORD_W-1:0] tgt);
		sched_res_t r;
		logic [SLOT_W-1:0] t;
		logic [WORD_W-1:0] d, part;
		int found, guard, live;
		r = '0;
		case (c)
			CMD_SCHEDULE: r.switched = ring_sched(now);
			CMD_CREATE: begin
				found = -1;
				for (int s = 0; s < MAX_TASKS; s++)
					if (!ring_used[s] && found < 0) found = s;
				if (found < 0) begin
					r.status = RES_FAIL;
				end else begin
					ring_used[found]  = 1'b1;
					ring_state[found] = ST_READY;
					ring_id[found]    = next_task_id;
					ring_wake[found]  = '0;
					r.created_id      = next_task_id;
					next_task_id      = next_task_id + 32'd1;
					ring_next[found]  = ring_next[cur_slot];
					ring_next[cur_slot] = SLOT_W'(found);
				end
			end
			CMD_SLEEP: begin
				d    = (ms / 32'd1000) * rate_hz;
				part = (ms % 32'd1000) * rate_hz;
				d    = d + part / 32'd1000;
				ring_state[cur_slot] = ST_SLEEP;
				ring_wake[cur_slot]  = now + d;
				r.switched = ring_sched(now);
			end
			CMD_KILL: begin
				t = cur_slot;
				guard = 256;
				r.status = RES_FAIL;
				do begin
					if (ring_id[t] == tgt && ring_state[t] != ST_DEAD) begin
						if (t == cur_slot) begin
							r.status = RES_CURRENT;
						end else begin
							ring_state[t] = ST_DEAD;
							r.status = RES_OK;
						end
						break;
					end
					t = ring_next[t];
					guard--;
				end while (t != cur_slot && guard > 0);
			end
			CMD_EXIT: begin
				ring_state[cur_slot] = ST_DEAD;
				r.switched = ring_sched(now);
			end
			default: ;
		endcase
		r.running_id = ring_id[cur_slot];
		live = 0;
		t = cur_slot;
		do begin
			if (ring_state[t] != ST_DEAD) live++;
			t = ring_next[t];
		end while (t != cur_slot && live < 256);
		r.live_count = LIVE_W'(live);
		return r;
	endfunction

	// stimulus
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [WORD_W-1:0] now,
		logic [WORD_W-1:0] ms, logic [WORD_W-1:0] tgt, logic typed, sched_res_t typed_res);
		sched_res_t r;
		int gap;
		cmd_ch.valid     <= 1'b1;
		cmd_ch.command   <= c;
		cmd_ch.now_tick  <= now;
		cmd_ch.delay_ms  <= ms;
		cmd_ch.target_id <= tgt;
		do @(posedge clk); while (!cmd_ch.ready);
		r = predict_cmd(c, now, ms, tgt);
		pending_res.push_back(typed ? typed_res : r);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: gap = 0;
			9:          gap = $urandom_range(20, 80);
			default:    gap = $urandom_range(1, 4);
		endcase
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_rate(logic [TICK_RATE_W-1:0] v);
		cmd_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		rate_hz = 32'(v);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		logic [CMD_W-1:0]  c;
		logic [WORD_W-1:0] ms, tgt;
		int k;
		k = $urandom_range(0, 99);
		if (k < 30)      c = CMD_SCHEDULE;
		else if (k < 52) c = CMD_CREATE;
		else if (k < 66) c = CMD_SLEEP;
		else if (k < 82) c = CMD_KILL;
		else if (k < 96) c = CMD_EXIT;
		else             c = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		// time mostly moves forward, now and then jumps anywhere
		case ($urandom_range(0, 19))
			0:       tick_now = $urandom;
			1:       tick_now = 32'hFFFF_FFFF;
			default: tick_now = tick_now + $urandom_range(0, 3000);
		endcase
		case ($urandom_range(0, 9))
			0:       ms = $urandom;
			1:       ms = 32'hFFFF_FFFF;
			default: ms = $urandom_range(0, 3000);
		endcase
		if ($urandom_range(0, 4) == 0) tgt = $urandom;
		else tgt = next_task_id - $urandom_range(0, 24);
		send_cmd(c, tick_now, ms, tgt, 1'b0, '0);
	endtask

	cmd_row_t dir_tab[] = '{
		'{CMD_SCHEDULE, 32'd0, 32'd0, 32'd0, 1'b1, '{RES_OK, 32'd0, 1'b0, 32'd0, 9'd1}},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b1, '{RES_OK, 32'd0, 1'b0, 32'd1, 9'd2}},
		'{CMD_SCHEDULE, 32'd5, 32'd0, 32'd0, 1'b1, '{RES_OK, 32'd1, 1'b1, 32'd0, 9'd2}},
		'{CMD_KILL, 32'd5, 32'd0, 32'd1, 1'b1, '{RES_CURRENT, 32'd1, 1'b0, 32'd0, 9'd2}},
		'{CMD_KILL, 32'd5, 32'd0, 32'hFFFF_FFFF, 1'b1, '{RES_FAIL, 32'd1, 1'b0, 32'd0, 9'd2}},
		'{CMD_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
		'{CMD_SLEEP, 32'd100, 32'd1500, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_SCHEDULE, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
		'{CMD_SCHEDULE, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_CREATE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_KILL, 32'd0, 32'd0, 32'd3, 1'b0, '0},
		'{CMD_EXIT, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_SCHEDULE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_UNKNOWN_LO, 32'd7, 32'd7, 32'd7, 1'b0, '0},
		'{CMD_UNKNOWN_HI, 32'd7, 32'd7, 32'd7, 1'b0, '0},
		'{CMD_EXIT, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
		'{CMD_SLEEP, 32'd0, 32'd999, 32'd0, 1'b0, '0}
	};

	initial begin
		cmd_ch.valid     <= 1'b0;
		cmd_ch.command   <= CMD_SCHEDULE;
		cmd_ch.now_tick  <= '0;
		cmd_ch.delay_ms  <= '0;
		cmd_ch.target_id <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.data      <= TICK_RATE_RST;
		ring_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_cmd(dir_tab[i].command, dir_tab[i].now_tick, dir_tab[i].delay_ms,
				dir_tab[i].target_id, dir_tab[i].typed, dir_tab[i].res);
		// enough creates to reach a full table at least once
		repeat (18) send_cmd(CMD_CREATE, tick_now, '0, '0, 1'b0, '0);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_rate(20'd1);
				2: write_rate(20'd1000000);
				3: write_rate(20'd0);
				4: write_rate(20'($urandom_range(1, 1000000)));
				default: ;
			endcase
			repeat (N_RANDOM / 5) send_random();
		end
		write_rate(20'hFFFFF);
		repeat (20) send_random();
		cmd_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// result side: random stalls, plus one long hold-off
	initial begin
		int taken_at_hold;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken_at_hold == 0 && pending_res.size() != 0 && $time > 20000) begin
				taken_at_hold = 1;
				res_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
				3: begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(20, 120)) @(posedge clk);
				end
				default: begin
					res_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 40)) @(posedge clk);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		sched_res_t e;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = pending_res.pop_front();
				if (res_ch.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res_ch.status);
					errors++;
				end
				if (res_ch.running_id !== e.running_id) begin
					$error("running_id exp %0d got %0d", e.running_id, res_ch.running_id);
					errors++;
				end
				if (res_ch.switched !== e.switched) begin
					$error("switched exp %0d got %0d", e.switched, res_ch.switched);
					errors++;
				end
				if (res_ch.created_id !== e.created_id) begin
					$error("created_id exp %0d got %0d", e.created_id, res_ch.created_id);
					errors++;
				end
				if (res_ch.live_count !== e.live_count) begin
					$error("live_count exp %0d got %0d", e.live_count, res_ch.live_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> sim.f
sv/rrts_pkg.sv
sv/rrts_ifs.sv
sv/rrts_div1000.sv
sv/round_robin_task_ring_scheduler_core.sv
dv/round_robin_task_ring_scheduler_core_tb.sv
